// ===== design/assert_macros.svh =====
// Assertion macros used by the line engine module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");

`endif

// ===== design/hlmc_pkg.sv =====
// Package: constants, types and functions of the hex line CRC checker.
package hlmc_pkg;

   localparam int LINE_CHARS_DEF = 32;

   localparam logic [7:0]  CHAR_NL  = 8'h0A;
   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;
   localparam logic [4:0]  HEX_BAD  = 5'd16;

   typedef struct packed {
      logic       valid;
      logic [7:0] char_in;
   } beat_type;

   typedef struct packed {
      logic [15:0] crc_shown;
      logic [31:0] received_crc_chars;
      logic [4:0]  line_length;
      logic [3:0]  data_bytes;
   } rsp_type;

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] d;
      if (c >= 8'h30 && c <= 8'h39) begin
         d = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         d = 5'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         d = 5'(c - 8'h37);
      end else begin
         d = HEX_BAD;
      end
      return d;
   endfunction

   function automatic logic [7:0] parse_pair(input logic [7:0] a, input logic [7:0] b);
      logic [4:0] hi;
      logic [4:0] lo;
      logic [7:0] r;
      hi = hex_digit(a);
      lo = hex_digit(b);
      if (hi[4]) begin
         r = 8'h00;
      end else if (lo[4]) begin
         r = {4'h0, hi[3:0]};
      end else begin
         r = {hi[3:0], lo[3:0]};
      end
      return r;
   endfunction

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

// ===== design/hlmc_in_stage.sv =====
// Input register: holds one character beat ahead of the line engine.
module hlmc_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_char_in,
   input  logic              advance,
   output hlmc_pkg::beat_type beat
);

   logic       valid_ff, valid_in;
   logic [7:0] char_ff,  char_in;

   assign req_ready = !valid_ff || advance;

   always_comb begin
      valid_in = valid_ff;
      char_in  = char_ff;
      if (req_ready) begin
         valid_in = req_valid;
         char_in  = req_char_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
   end

   assign beat.valid   = valid_ff;
   assign beat.char_in = char_ff;

endmodule

// ===== design/hlmc_line_core.sv =====
// Line engine: tail window, pair parsing, CRC update and end-of-line result.
`include "assert_macros.svh"

module hlmc_line_core #(
   parameter int LINE_CHARS = hlmc_pkg::LINE_CHARS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  hlmc_pkg::beat_type beat,
   input  logic               out_busy,
   output logic               advance,
   output logic               rsp_load,
   output hlmc_pkg::rsp_type  rsp_data
);

   localparam int KW = $clog2(LINE_CHARS);
   localparam logic [KW-1:0] KEEP_MAX = KW'(LINE_CHARS - 1);
   localparam logic [KW-1:0] FOUR     = KW'(4);
   localparam logic [KW-1:0] TWO      = KW'(2);

   logic [7:0]    tail_ff [4];
   logic [7:0]    tail_in [4];
   logic [KW-1:0] kept_ff,  kept_in;
   logic [7:0]    first_ff, first_in;
   logic [15:0]   crc_ff,   crc_in;
   logic [KW-1:0] bytes_ff, bytes_in;

   logic          is_nl;
   logic [15:0]   crc_end;
   logic [KW-1:0] bytes_end;
   logic [31:0]   rx_chars;
   logic [7:0]    short_a, short_b;
   logic [KW+4:0] len_wide;
   logic [KW+3:0] bytes_wide;

   assign is_nl    = (beat.char_in == hlmc_pkg::CHAR_NL);
   assign advance  = beat.valid && !(is_nl && out_busy);
   assign rsp_load = advance && is_nl;

   // short line of two or three characters: the pair is the first two characters in the window
   assign short_a = kept_ff[0] ? tail_ff[1] : tail_ff[2];
   assign short_b = kept_ff[0] ? tail_ff[2] : tail_ff[3];

   always_comb begin
      rx_chars  = 32'h0;
      crc_end   = crc_ff;
      bytes_end = bytes_ff;
      if (kept_ff >= FOUR) begin
         rx_chars = {tail_ff[0], tail_ff[1], tail_ff[2], tail_ff[3]};
      end else if (kept_ff >= TWO) begin
         crc_end   = hlmc_pkg::crc_byte(crc_ff, hlmc_pkg::parse_pair(short_a, short_b));
         bytes_end = bytes_ff + KW'(1);
      end
   end

   assign len_wide   = {5'b0, kept_ff};
   assign bytes_wide = {4'b0, bytes_end};

   assign rsp_data.crc_shown          = {crc_end[7:0], crc_end[15:8]};
   assign rsp_data.received_crc_chars = rx_chars;
   assign rsp_data.line_length        = len_wide[4:0];
   assign rsp_data.data_bytes         = bytes_wide[3:0];

   always_comb begin
      tail_in  = tail_ff;
      kept_in  = kept_ff;
      first_in = first_ff;
      crc_in   = crc_ff;
      bytes_in = bytes_ff;
      if (advance) begin
         if (is_nl) begin
            tail_in  = '{default: 8'h00};
            kept_in  = '0;
            first_in = 8'h00;
            crc_in   = hlmc_pkg::CRC_INIT;
            bytes_in = '0;
         end else if (kept_ff < KEEP_MAX) begin
            if (kept_ff >= FOUR) begin
               if (!kept_ff[0]) begin
                  first_in = tail_ff[0];
               end else begin
                  crc_in   = hlmc_pkg::crc_byte(crc_ff,
                                hlmc_pkg::parse_pair(first_ff, tail_ff[0]));
                  bytes_in = bytes_ff + KW'(1);
               end
            end
            tail_in[0] = tail_ff[1];
            tail_in[1] = tail_ff[2];
            tail_in[2] = tail_ff[3];
            tail_in[3] = beat.char_in;
            kept_in    = kept_ff + KW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tail_ff  <= '{default: 8'h00};
         kept_ff  <= '0;
         first_ff <= 8'h00;
         crc_ff   <= hlmc_pkg::CRC_INIT;
         bytes_ff <= '0;
      end else begin
         tail_ff  <= tail_in;
         kept_ff  <= kept_in;
         first_ff <= first_in;
         crc_ff   <= crc_in;
         bytes_ff <= bytes_in;
      end
   end

   `ASSERT_IMPLY(a_kept_bound, clock, reset, 1'b1, kept_ff <= KEEP_MAX)
   `ASSERT_NEXT(a_nl_clears, clock, reset, rsp_load, kept_ff == '0 && bytes_ff == '0)
   `ASSERT_IMPLY(a_crc_idle, clock, reset, kept_ff <= KW'(5),
                 crc_ff == hlmc_pkg::CRC_INIT && bytes_ff == '0)

endmodule

// ===== design/hlmc_out_reg.sv =====
// Result register: holds one finished line result until the beat is taken.
module hlmc_out_reg (
   input  logic              clock,
   input  logic              reset,
   input  logic              rsp_load,
   input  hlmc_pkg::rsp_type rsp_data,
   output logic              out_busy,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [15:0]       rsp_crc_shown,
   output logic [31:0]       rsp_received_crc_chars,
   output logic [4:0]        rsp_line_length,
   output logic [3:0]        rsp_data_bytes
);

   logic              valid_ff, valid_in;
   hlmc_pkg::rsp_type data_ff,  data_in;

   assign out_busy = valid_ff && !rsp_ready;

   always_comb begin
      valid_in = valid_ff && !rsp_ready;
      data_in  = data_ff;
      if (rsp_load) begin
         valid_in = 1'b1;
         data_in  = rsp_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid              = valid_ff;
   assign rsp_crc_shown          = data_ff.crc_shown;
   assign rsp_received_crc_chars = data_ff.received_crc_chars;
   assign rsp_line_length        = data_ff.line_length;
   assign rsp_data_bytes         = data_ff.data_bytes;

endmodule

// ===== design/hex_line_modbus_crc.sv =====
// Newline beats go input register -> line engine -> result register driving rsp_.
// Throughput: one char per cycle unless a newline stalls; at most one CRC byte per beat.
// A newline stalls only while the single result register still holds an untaken beat.
// Reset is synchronous, active high: line state returns to empty, CRC to FFFF.
// No clearing pass; the block accepts beats as soon as reset is released.
module hex_line_modbus_crc #(
   parameter int LINE_CHARS = hlmc_pkg::LINE_CHARS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_crc_shown,
   output logic [31:0] rsp_received_crc_chars,
   output logic [4:0]  rsp_line_length,
   output logic [3:0]  rsp_data_bytes
);

   hlmc_pkg::beat_type beat;
   hlmc_pkg::rsp_type  rsp_data;
   logic               advance;
   logic               rsp_load;
   logic               out_busy;

   hlmc_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_char_in (req_char_in),
      .advance     (advance),
      .beat        (beat)
   );

   hlmc_line_core #(
      .LINE_CHARS (LINE_CHARS)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .beat     (beat),
      .out_busy (out_busy),
      .advance  (advance),
      .rsp_load (rsp_load),
      .rsp_data (rsp_data)
   );

   hlmc_out_reg u_out (
      .clock                  (clock),
      .reset                  (reset),
      .rsp_load               (rsp_load),
      .rsp_data               (rsp_data),
      .out_busy               (out_busy),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_crc_shown          (rsp_crc_shown),
      .rsp_received_crc_chars (rsp_received_crc_chars),
      .rsp_line_length        (rsp_line_length),
      .rsp_data_bytes         (rsp_data_bytes)
   );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the hex line CRC checker: directed and random lines in, summaries compared out.
`timescale 1ns / 100ps

module tb;

   localparam int KEEP_MAX    = hlmc_pkg::LINE_CHARS_DEF - 1;
   localparam int CHAR_TARGET = 1550;
   localparam int CALM_TAIL   = 150;
   localparam int QUIET_LIMIT = 600;

   typedef struct {
      logic [15:0] crc_shown;
      logic [31:0] received_crc_chars;
      logic [4:0]  line_length;
      logic [3:0]  data_bytes;
   } line_summary_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_in = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [15:0] rsp_crc_shown;
   logic [31:0] rsp_received_crc_chars;
   logic [4:0]  rsp_line_length;
   logic [3:0]  rsp_data_bytes;

   logic [7:0]       char_backlog[$];
   line_summary_type line_results_due[$];
   line_summary_type due;

   logic [7:0]  tail_q[4];
   int          kept;
   logic [7:0]  held_first;
   logic [15:0] crc_run;
   int          fed;

   int send_gap;
   int hold_left;
   int quiet_cycles = 0;
   int mismatches = 0;

   hex_line_modbus_crc dut (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_char_in            (req_char_in),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_crc_shown          (rsp_crc_shown),
      .rsp_received_crc_chars (rsp_received_crc_chars),
      .rsp_line_length        (rsp_line_length),
      .rsp_data_bytes         (rsp_data_bytes)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [15:0] crc_fold(input logic [15:0] acc, input logic [7:0] b);
      logic [15:0] r;
      logic        fb;
      r = acc;
      for (int k = 0; k < 8; k++) begin
         fb = r[0] ^ b[k];
         r  = {1'b0, r[15:1]};
         if (fb) begin
            r = r ^ hlmc_pkg::CRC_POLY;
         end
      end
      return r;
   endfunction

   function automatic bit hex_nibble(input logic [7:0] ch, output logic [3:0] v);
      logic [7:0] lower;
      v = 4'h0;
      lower = ch | 8'h20;
      if (ch >= "0" && ch <= "9") begin
         v = ch[3:0];
         return 1'b1;
      end
      if ((ch == lower || ch == (lower & 8'hDF)) && lower >= "a" && lower <= "f") begin
         v = lower[3:0] + 4'd9;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic logic [7:0] pair_byte(input logic [7:0] a, input logic [7:0] b);
      logic [3:0] hi;
      logic [3:0] lo;
      if (!hex_nibble(a, hi)) begin
         return 8'h00;
      end
      if (!hex_nibble(b, lo)) begin
         return {4'h0, hi};
      end
      return {hi, lo};
   endfunction

   function automatic void clear_line();
      for (int i = 0; i < 4; i++) begin
         tail_q[i] = 8'h00;
      end
      kept       = 0;
      held_first = 8'h00;
      crc_run    = hlmc_pkg::CRC_INIT;
      fed        = 0;
   endfunction

   function automatic void feed(input logic [7:0] b);
      crc_run = crc_fold(crc_run, b);
      fed++;
   endfunction

   function automatic void absorb_char(input logic [7:0] ch);
      line_summary_type s;
      int               skip;
      if (ch != hlmc_pkg::CHAR_NL) begin
         if (kept < KEEP_MAX) begin
            if (kept >= 4) begin
               if (((kept - 4) % 2) == 0) begin
                  held_first = tail_q[0];
               end else begin
                  feed(pair_byte(held_first, tail_q[0]));
               end
            end
            tail_q[0] = tail_q[1];
            tail_q[1] = tail_q[2];
            tail_q[2] = tail_q[3];
            tail_q[3] = ch;
            kept++;
         end
         return;
      end
      s.received_crc_chars = 32'h0;
      if (kept >= 4) begin
         s.received_crc_chars = {tail_q[0], tail_q[1], tail_q[2], tail_q[3]};
      end else if (kept >= 2) begin
         skip = 4 - kept;
         feed(pair_byte(tail_q[skip], tail_q[skip + 1]));
      end
      s.crc_shown   = {crc_run[7:0], crc_run[15:8]};
      s.line_length = kept[4:0];
      s.data_bytes  = fed[3:0];
      line_results_due.push_back(s);
      clear_line();
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         return 8'h30 + {4'h0, v};
      end
      return ($urandom_range(0, 1) ? 8'h61 : 8'h41) + {4'h0, v} - 8'd10;
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] r;
      do begin
         r = 8'($urandom_range(0, 255));
      end while (r == hlmc_pkg::CHAR_NL);
      return r;
   endfunction

   function automatic bit want_pause();
      if (char_backlog.size() < CALM_TAIL || ((char_backlog.size() / 120) % 3) == 0) begin
         return 1'b0;
      end
      return $urandom_range(0, 5) == 0;
   endfunction

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) begin
         char_backlog.push_back(s[i]);
      end
   endtask

   task automatic add_random_line();
      logic [7:0]  line[$];
      logic [15:0] sum;
      logic [15:0] shown;
      logic [7:0]  b;
      int          kind;
      int          n;
      int          cut;
      kind = $urandom_range(0, 19);
      sum  = hlmc_pkg::CRC_INIT;
      if (kind < 13) begin
         n = (kind == 0) ? $urandom_range(14, 16) : $urandom_range(0, 13);
         for (int i = 0; i < n; i++) begin
            b = 8'($urandom_range(0, 255));
            line.push_back(hex_char(b[7:4]));
            line.push_back(hex_char(b[3:0]));
            sum = crc_fold(sum, b);
         end
         shown = {sum[7:0], sum[15:8]};
         if ($urandom_range(0, 3) == 0) begin
            shown = 16'($urandom_range(0, 65535));
         end
         for (int i = 3; i >= 0; i--) begin
            line.push_back(hex_char(shown[i*4 +: 4]));
         end
         if (kind >= 10) begin
            if ($urandom_range(0, 1)) begin
               line[$urandom_range(0, line.size() - 1)] = noise_char();
            end else begin
               cut = $urandom_range(0, line.size() - 1);
               while (line.size() > cut) begin
                  void'(line.pop_back());
               end
            end
         end
      end else if (kind < 17) begin
         n = $urandom_range(0, 40);
         for (int i = 0; i < n; i++) begin
            line.push_back(noise_char());
         end
      end else begin
         n = $urandom_range(0, 5);
         for (int i = 0; i < n; i++) begin
            line.push_back($urandom_range(0, 1) ? hex_char(4'($urandom_range(0, 15)))
                                                : noise_char());
         end
      end
      foreach (line[i]) begin
         char_backlog.push_back(line[i]);
      end
      char_backlog.push_back(hlmc_pkg::CHAR_NL);
   endtask

   // driver: hold the beat until taken, then advance or pause
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_char(req_char_in);
         end
         if (!req_valid || req_ready) begin
            if (send_gap == 0 && want_pause()) begin
               send_gap = $urandom_range(1, 18);
            end
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (char_backlog.size() > 0) begin
               req_valid   <= 1'b1;
               req_char_in <= char_backlog.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left = 0;
      end else begin
         if (hold_left == 0 && want_pause()) begin
            hold_left = $urandom_range(1, 18);
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor: compare each result beat with the oldest line summary
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (line_results_due.size() == 0) begin
            $display("%0t: unexpected result beat crc_shown %h chars %h length %0d bytes %0d",
                     $time, rsp_crc_shown, rsp_received_crc_chars, rsp_line_length,
                     rsp_data_bytes);
            mismatches++;
         end else begin
            due = line_results_due.pop_front();
            if (rsp_crc_shown !== due.crc_shown) begin
               $display("%0t: crc_shown expected %h actual %h",
                        $time, due.crc_shown, rsp_crc_shown);
               mismatches++;
            end
            if (rsp_received_crc_chars !== due.received_crc_chars) begin
               $display("%0t: received_crc_chars expected %h actual %h",
                        $time, due.received_crc_chars, rsp_received_crc_chars);
               mismatches++;
            end
            if (rsp_line_length !== due.line_length) begin
               $display("%0t: line_length expected %0d actual %0d",
                        $time, due.line_length, rsp_line_length);
               mismatches++;
            end
            if (rsp_data_bytes !== due.data_bytes) begin
               $display("%0t: data_bytes expected %0d actual %0d",
                        $time, due.data_bytes, rsp_data_bytes);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (char_backlog.size() == 0 && !req_valid && line_results_due.size() == 0)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   initial begin
      clear_line();
      char_backlog.push_back(hlmc_pkg::CHAR_NL);
      push_text("A");
      char_backlog.push_back(hlmc_pkg::CHAR_NL);
      push_text("g7");
      char_backlog.push_back(hlmc_pkg::CHAR_NL);
      push_text("4Gz");
      char_backlog.push_back(hlmc_pkg::CHAR_NL);
      push_text("09afAF/:@G`g1e2D3c4B5a6F7");
      char_backlog.push_back(8'h00);
      char_backlog.push_back(8'h0D);
      char_backlog.push_back(8'hFF);
      char_backlog.push_back(8'h80);
      char_backlog.push_back(8'h7F);
      char_backlog.push_back(8'h20);
      char_backlog.push_back(8'h30);
      char_backlog.push_back(8'h41);
      char_backlog.push_back(hlmc_pkg::CHAR_NL);
      while (char_backlog.size() < CHAR_TARGET) begin
         add_random_line();
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (char_backlog.size() != 0 || req_valid || line_results_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+design
design/hlmc_pkg.sv
design/hlmc_in_stage.sv
design/hlmc_line_core.sv
design/hlmc_out_reg.sv
design/hex_line_modbus_crc.sv
bench/tb.sv
